@@ sv/vtlt_pkg.sv @@
// Package for the voxel track-length tally: register indexes, reset values,
// widths, request kinds and the shared command struct. No dependencies.
package vtlt_pkg;

   localparam int CellsXDefault = 16;
   localparam int CellsYDefault = 16;
   localparam int CellsZDefault = 16;
   localparam int StoreDepth = 4096;
   localparam int StoreAw = 12;
   localparam logic [47:0] AccMax = 48'hFFFF_FFFF_FFFF;
   localparam logic signed [63:0] TSat = 64'sd1 <<< 40;

   localparam logic [2:0] RegMinX = 3'd0;
   localparam logic [2:0] RegMinY = 3'd1;
   localparam logic [2:0] RegMinZ = 3'd2;
   localparam logic [2:0] RegSizeX = 3'd3;
   localparam logic [2:0] RegSizeY = 3'd4;
   localparam logic [2:0] RegSizeZ = 3'd5;

   localparam logic signed [31:0] MinReset = -32'sd524288;
   localparam logic [30:0] SizeReset = 31'd65536;

   typedef enum logic {
      REQ_TALLY = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   typedef struct packed {
      req_kind_type kind;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic signed [31:0] dz;
      logic [30:0] len;
      logic [31:0] w;
      logic [11:0] idx;
   } cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RD,
      ST_RDWAIT,
      ST_CLIP_SET,
      ST_CLIP_DIV,
      ST_CLIP_ACC,
      ST_START_MUL,
      ST_START_DIV,
      ST_START_SET,
      ST_CROSS_SET,
      ST_CROSS_DIV,
      ST_CROSS_ACC,
      ST_PICK,
      ST_MUL,
      ST_MEMRD,
      ST_MEMWAIT,
      ST_MEMWR,
      ST_STEP,
      ST_DONE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [47:0] tally_value;
      logic [5:0] cells_visited;
      logic mesh_hit;
   } rsp_type;

endpackage

@@ sv/vtlt_front.sv @@
// Front end: accepts request beats and holds them in a two-entry queue.
// Depends on vtlt_pkg.
module vtlt_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  vtlt_pkg::cmd_type in_cmd,
   output logic out_valid,
   input  logic out_ready,
   output vtlt_pkg::cmd_type out_cmd
);

   vtlt_pkg::cmd_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic push, pop;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_cmd = q_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
      if (push) begin
         q_ff[wp_ff] <= in_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != 2'd0) else $error("pop empty");
`endif

endmodule

@@ sv/vtlt_div.sv @@
// Restoring divider for hit times and cell indexes, one quotient bit a cycle.
// Depends on nothing.
module vtlt_div (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [61:0] num,
   input  logic [31:0] den,
   output logic busy,
   output logic [61:0] quo
);

   logic [61:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] d_ff, d_in;
   logic [5:0] n_ff, n_in;
   logic busy_ff, busy_in;
   logic [32:0] sh;

   assign busy = busy_ff;
   assign quo = q_ff;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      sh = {r_ff[31:0], q_ff[61]};
      if (start) begin
         q_in = num;
         r_in = 33'd0;
         d_in = den;
         n_in = 6'd61;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[60:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[60:0], 1'b0};
         end
         n_in = n_ff - 6'd1;
         if (n_ff == 6'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      n_ff <= n_in;
   end

endmodule

@@ sv/vtlt_back.sv @@
// Back end: clips the segment, finds the first cell, walks cells in DDA order
// and updates or reads the tally memory. Depends on vtlt_pkg and vtlt_div.
module vtlt_back #(
   parameter int CELLS_X = vtlt_pkg::CellsXDefault,
   parameter int CELLS_Y = vtlt_pkg::CellsYDefault,
   parameter int CELLS_Z = vtlt_pkg::CellsZDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic cmd_valid,
   output logic cmd_ready,
   input  vtlt_pkg::cmd_type cmd,
   input  logic signed [31:0] min_x,
   input  logic signed [31:0] min_y,
   input  logic signed [31:0] min_z,
   input  logic [30:0] size_x,
   input  logic [30:0] size_y,
   input  logic [30:0] size_z,
   output logic rsp_valid,
   input  logic rsp_ready,
   output vtlt_pkg::rsp_type rsp
);

   localparam int ItMax = CELLS_X + CELLS_Y + CELLS_Z + 1;
   localparam int ItW = $clog2(ItMax + 1);

   vtlt_pkg::state_type st_ff, st_in;
   vtlt_pkg::cmd_type c_ff, c_in;
   logic [47:0] mem [vtlt_pkg::StoreDepth];
   logic [47:0] rd_ff;
   logic [11:0] clr_ff, clr_in;
   logic [1:0] ax_ff, ax_in;
   logic sub_ff, sub_in;
   logic signed [63:0] tmin_ff, tmin_in, tmax_ff, tmax_in, t_ff, t_in;
   logic signed [63:0] ta_ff, ta_in, tn_ff, tn_in;
   logic signed [63:0] tc_ff [3];
   logic signed [63:0] tc_in [3];
   logic signed [63:0] pos_ff, pos_in;
   logic signed [9:0] ci_ff [3];
   logic signed [9:0] ci_in [3];
   logic miss_ff, miss_in;
   logic [5:0] vis_ff, vis_in;
   logic [ItW-1:0] it_ff, it_in;
   logic [63:0] prod_ff, prod_in;
   logic [11:0] addr_ff, addr_in;
   logic neg_ff, neg_in;
   logic sat_ff, sat_in;
   vtlt_pkg::rsp_type r_ff, r_in;
   logic mwe;
   logic [47:0] mwd;

   logic dstart, dbusy;
   logic [61:0] dnum, dquo;
   logic [31:0] dden;

   vtlt_div u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(dden),
      .busy(dbusy), .quo(dquo)
   );

   logic signed [31:0] ap, ad, amn;
   logic [30:0] asz;
   logic [8:0] an;
   logic signed [63:0] amx, plane, numv, hq, mul, fl;
   logic [63:0] mn, md, sum;
   logic [11:0] lin;

   always_comb begin
      case (ax_ff)
         2'd0: begin ap = c_ff.px; ad = c_ff.dx; amn = min_x; asz = size_x;
            an = 9'(CELLS_X); end
         2'd1: begin ap = c_ff.py; ad = c_ff.dy; amn = min_y; asz = size_y;
            an = 9'(CELLS_Y); end
         default: begin ap = c_ff.pz; ad = c_ff.dz; amn = min_z; asz = size_z;
            an = 9'(CELLS_Z); end
      endcase
      amx = 64'(amn) + 64'(asz) * 64'(an);
   end

   assign cmd_ready = st_ff == vtlt_pkg::ST_IDLE;
   assign rsp_valid = st_ff == vtlt_pkg::ST_OUT;
   assign rsp = r_ff;

   always_comb begin
      st_in = st_ff; c_in = c_ff; clr_in = clr_ff; ax_in = ax_ff; sub_in = sub_ff;
      tmin_in = tmin_ff; tmax_in = tmax_ff; t_in = t_ff; ta_in = ta_ff;
      tn_in = tn_ff; pos_in = pos_ff; miss_in = miss_ff; vis_in = vis_ff;
      it_in = it_ff; prod_in = prod_ff; addr_in = addr_ff; neg_in = neg_ff;
      sat_in = sat_ff; r_in = r_ff;
      for (int a = 0; a < 3; a++) begin
         tc_in[a] = tc_ff[a];
         ci_in[a] = ci_ff[a];
      end
      dstart = 1'b0; dnum = 62'd0; dden = 32'd0; mwe = 1'b0; mwd = 48'd0;
      plane = 64'sd0; numv = 64'sd0; mn = 64'd0; md = 64'd0; hq = 64'sd0;
      mul = 64'sd0; fl = 64'sd0; sum = 64'd0; lin = 12'd0;
      case (st_ff)
         vtlt_pkg::ST_CLEAR: begin
            mwe = 1'b1; addr_in = clr_ff;
            clr_in = clr_ff + 12'd1;
            if (clr_ff == 12'hFFF) st_in = vtlt_pkg::ST_IDLE;
         end
         vtlt_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               c_in = cmd;
               r_in = '0;
               if (cmd.kind == vtlt_pkg::REQ_READ) begin
                  addr_in = cmd.idx;
                  st_in = vtlt_pkg::ST_RD;
               end else if (cmd.len == 31'd0 || size_x == 31'd0 || size_y == 31'd0
                            || size_z == 31'd0) begin
                  st_in = vtlt_pkg::ST_OUT;
               end else begin
                  tmin_in = 64'sd0; tmax_in = 64'(cmd.len); ax_in = 2'd0;
                  sub_in = 1'b0; miss_in = 1'b0;
                  st_in = vtlt_pkg::ST_CLIP_SET;
               end
            end
         end
         vtlt_pkg::ST_RD: st_in = vtlt_pkg::ST_RDWAIT;
         vtlt_pkg::ST_RDWAIT: begin
            r_in.tally_value = rd_ff;
            st_in = vtlt_pkg::ST_OUT;
         end
         vtlt_pkg::ST_CLIP_SET, vtlt_pkg::ST_CROSS_SET: begin
            if (st_ff == vtlt_pkg::ST_CLIP_SET) begin
               plane = sub_ff ? amx : 64'(amn);
            end else begin
               plane = 64'(amn) + 64'(ci_ff[ax_ff] + (ad > 0 ? 10'sd1 : 10'sd0))
                       * 64'(asz);
            end
            numv = plane - 64'(ap);
            neg_in = (numv < 0) != (ad < 0);
            mn = numv < 0 ? 64'(-numv) : 64'(numv);
            md = ad < 0 ? 64'(-64'(ad)) : 64'(ad);
            sat_in = mn >= 64'h1_0000_0000;
            dnum = {mn[31:0], 30'd0};
            dden = md[31:0];
            if (st_ff == vtlt_pkg::ST_CLIP_SET && ad == 32'sd0) begin
               if (!(64'(ap) >= 64'(amn) && 64'(ap) < amx)) miss_in = 1'b1;
               st_in = vtlt_pkg::ST_CLIP_ACC;
               sub_in = 1'b1;
            end else if (st_ff == vtlt_pkg::ST_CROSS_SET && ad == 32'sd0) begin
               tc_in[ax_ff] = vtlt_pkg::TSat;
               st_in = vtlt_pkg::ST_CROSS_ACC;
               sat_in = 1'b0;
            end else begin
               dstart = 1'b1;
               st_in = st_ff == vtlt_pkg::ST_CLIP_SET ? vtlt_pkg::ST_CLIP_DIV
                       : vtlt_pkg::ST_CROSS_DIV;
            end
         end
         vtlt_pkg::ST_CLIP_DIV, vtlt_pkg::ST_CROSS_DIV: begin
            if (!dbusy) begin
               hq = (sat_ff || dquo > 62'(vtlt_pkg::TSat)) ? vtlt_pkg::TSat
                    : 64'(dquo);
               hq = neg_ff ? -hq : hq;
               if (st_ff == vtlt_pkg::ST_CLIP_DIV) begin
                  if (!sub_ff) begin
                     ta_in = hq; sub_in = 1'b1; st_in = vtlt_pkg::ST_CLIP_SET;
                  end else begin
                     if (ta_ff > hq) begin
                        if (ta_ff < tmax_ff) tmax_in = ta_ff;
                        if (hq > tmin_ff) tmin_in = hq;
                     end else begin
                        if (ta_ff > tmin_ff) tmin_in = ta_ff;
                        if (hq < tmax_ff) tmax_in = hq;
                     end
                     st_in = vtlt_pkg::ST_CLIP_ACC;
                  end
               end else begin
                  tc_in[ax_ff] = hq;
                  st_in = vtlt_pkg::ST_CROSS_ACC;
               end
            end
         end
         vtlt_pkg::ST_CLIP_ACC: begin
            sub_in = 1'b0;
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0;
               if (miss_ff || tmax_in <= tmin_in) st_in = vtlt_pkg::ST_OUT;
               else begin
                  r_in.mesh_hit = 1'b1;
                  st_in = vtlt_pkg::ST_START_MUL;
               end
            end else begin
               ax_in = ax_ff + 2'd1;
               st_in = vtlt_pkg::ST_CLIP_SET;
            end
         end
         vtlt_pkg::ST_START_MUL: begin
            prod_in = 64'(64'(ad) * 64'({1'b0, tmin_ff[30:0]}));
            st_in = vtlt_pkg::ST_START_DIV;
         end
         vtlt_pkg::ST_START_DIV: begin
            mul = $signed(prod_ff);
            fl = mul >>> 30;
            pos_in = 64'(ap) + fl - 64'(amn);
            if (pos_in < 0) begin
               ci_in[ax_ff] = 10'sd0;
               st_in = vtlt_pkg::ST_START_SET;
            end else begin
               dnum = 62'(pos_in);
               dden = {1'b0, asz};
               dstart = 1'b1;
               st_in = vtlt_pkg::ST_START_SET;
            end
         end
         vtlt_pkg::ST_START_SET: begin
            if (!dbusy) begin
               if (pos_ff >= 0) begin
                  ci_in[ax_ff] = (dquo > 62'(an) - 62'd1) ? 10'(an - 9'd1)
                                 : 10'(dquo[8:0]);
               end
               if (ax_ff == 2'd2) begin
                  ax_in = 2'd0; t_in = tmin_ff; vis_in = 6'd0; it_in = '0;
                  st_in = vtlt_pkg::ST_CROSS_SET;
               end else begin
                  ax_in = ax_ff + 2'd1;
                  st_in = vtlt_pkg::ST_START_MUL;
               end
            end
         end
         vtlt_pkg::ST_CROSS_ACC: begin
            if (ax_ff == 2'd2) begin
               ax_in = 2'd0;
               st_in = vtlt_pkg::ST_PICK;
            end else begin
               ax_in = ax_ff + 2'd1;
               st_in = vtlt_pkg::ST_CROSS_SET;
            end
         end
         vtlt_pkg::ST_PICK: begin
            tn_in = tmax_ff;
            if (c_ff.dx != 0 && tc_ff[0] < tn_in) tn_in = tc_ff[0];
            if (c_ff.dy != 0 && tc_ff[1] < tn_in) tn_in = tc_ff[1];
            if (c_ff.dz != 0 && tc_ff[2] < tn_in) tn_in = tc_ff[2];
            lin = (12'(ci_ff[2][8:0]) * 12'(CELLS_Y) + 12'(ci_ff[1][8:0]))
                  * 12'(CELLS_X) + 12'(ci_ff[0][8:0]);
            addr_in = lin;
            st_in = tn_in > t_ff ? vtlt_pkg::ST_MUL : vtlt_pkg::ST_STEP;
         end
         vtlt_pkg::ST_MUL: begin
            prod_in = 64'(c_ff.w) * 64'(tn_ff[30:0] - t_ff[30:0]);
            st_in = vtlt_pkg::ST_MEMRD;
         end
         vtlt_pkg::ST_MEMRD: begin
            t_in = tn_ff;
            st_in = prod_ff[63:8] != 56'd0 ? vtlt_pkg::ST_MEMWAIT : vtlt_pkg::ST_STEP;
         end
         vtlt_pkg::ST_MEMWAIT: st_in = vtlt_pkg::ST_MEMWR;
         vtlt_pkg::ST_MEMWR: begin
            sum = 64'(rd_ff) + {8'd0, prod_ff[63:8]};
            mwe = 1'b1;
            mwd = sum > 64'(vtlt_pkg::AccMax) ? vtlt_pkg::AccMax : sum[47:0];
            if (vis_ff != 6'd63) vis_in = vis_ff + 6'd1;
            st_in = vtlt_pkg::ST_STEP;
         end
         vtlt_pkg::ST_STEP: begin
            st_in = vtlt_pkg::ST_CROSS_SET;
            if (t_ff >= tmax_ff) st_in = vtlt_pkg::ST_DONE;
            else begin
               if (c_ff.dx != 0 && tn_ff == tc_ff[0])
                  ci_in[0] = ci_ff[0] + (c_ff.dx > 0 ? 10'sd1 : -10'sd1);
               else if (c_ff.dy != 0 && tn_ff == tc_ff[1])
                  ci_in[1] = ci_ff[1] + (c_ff.dy > 0 ? 10'sd1 : -10'sd1);
               else
                  ci_in[2] = ci_ff[2] + (c_ff.dz > 0 ? 10'sd1
                             : (c_ff.dz < 0 ? -10'sd1 : 10'sd0));
               if (ci_in[0] < 0 || ci_in[1] < 0 || ci_in[2] < 0
                   || ci_in[0] >= 10'(CELLS_X) || ci_in[1] >= 10'(CELLS_Y)
                   || ci_in[2] >= 10'(CELLS_Z) || it_ff == ItW'(ItMax - 1))
                  st_in = vtlt_pkg::ST_DONE;
               it_in = it_ff + 1'b1;
            end
         end
         vtlt_pkg::ST_DONE: begin
            r_in.cells_visited = vis_ff;
            st_in = vtlt_pkg::ST_OUT;
         end
         vtlt_pkg::ST_OUT: begin
            if (rsp_ready) st_in = vtlt_pkg::ST_IDLE;
         end
         default: st_in = vtlt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= vtlt_pkg::ST_CLEAR;
         clr_ff <= 12'd0;
      end else begin
         st_ff <= st_in;
         clr_ff <= clr_in;
      end
      c_ff <= c_in; ax_ff <= ax_in; sub_ff <= sub_in; tmin_ff <= tmin_in;
      tmax_ff <= tmax_in; t_ff <= t_in; ta_ff <= ta_in; tn_ff <= tn_in;
      pos_ff <= pos_in; miss_ff <= miss_in; vis_ff <= vis_in; it_ff <= it_in;
      prod_ff <= prod_in; addr_ff <= addr_in; neg_ff <= neg_in; sat_ff <= sat_in;
      r_ff <= r_in;
      for (int a = 0; a < 3; a++) begin
         tc_ff[a] <= tc_in[a];
         ci_ff[a] <= ci_in[a];
      end
   end

   always_ff @(posedge clock) begin
      if (mwe) begin
         mem[st_ff == vtlt_pkg::ST_CLEAR ? clr_ff : addr_ff] <= mwd;
      end
      rd_ff <= mem[addr_ff];
   end

`ifndef SYNTHESIS
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("rsp moved");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> !rsp_valid) else $error("overlap");
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      dstart |-> !dbusy) else $error("divider restarted");
`endif

endmodule

@@ sv/voxel_track_length_tally.sv @@
// Voxel track-length tally top level: request queue, walker, and registers.
// Tallies use the restoring divider up to six times to clip, up to three
// times for the first cell and up to three times per walk step. Throughput:
// one item at a time in the walker; the queue holds two more. Reset:
// synchronous; a pass that clears the whole tally memory follows, during
// which up to two beats wait in the queue.
module voxel_track_length_tally #(
   parameter int CELLS_X = vtlt_pkg::CellsXDefault,
   parameter int CELLS_Y = vtlt_pkg::CellsYDefault,
   parameter int CELLS_Z = vtlt_pkg::CellsZDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // start_x, start_y, start_z, dir_x, dir_y, dir_z, seg_len, weight_per_length,
   // cell_index, zero fill
   input  logic [271:0] req_tdata,
   // req_type
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tally_value, cells_visited, mesh_hit, zero fill
   output logic [55:0] rsp_tdata,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [4:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   vtlt_pkg::cmd_type in_cmd, q_cmd;
   vtlt_pkg::rsp_type rsp;
   logic q_valid, q_ready;
   logic signed [31:0] minx_ff, miny_ff, minz_ff;
   logic [30:0] sx_ff, sy_ff, sz_ff;
   logic [2:0] ridx;

   assign in_cmd.kind = vtlt_pkg::req_kind_type'(req_tuser);
   assign in_cmd.px = req_tdata[31:0];
   assign in_cmd.py = req_tdata[63:32];
   assign in_cmd.pz = req_tdata[95:64];
   assign in_cmd.dx = req_tdata[127:96];
   assign in_cmd.dy = req_tdata[159:128];
   assign in_cmd.dz = req_tdata[191:160];
   assign in_cmd.len = req_tdata[222:192];
   assign in_cmd.w = req_tdata[254:223];
   assign in_cmd.idx = req_tdata[266:255];

   assign csr_pready = 1'b1;
   assign ridx = csr_paddr[4:2];

   always_comb begin
      case (ridx)
         vtlt_pkg::RegMinX: csr_prdata = minx_ff;
         vtlt_pkg::RegMinY: csr_prdata = miny_ff;
         vtlt_pkg::RegMinZ: csr_prdata = minz_ff;
         vtlt_pkg::RegSizeX: csr_prdata = {1'b0, sx_ff};
         vtlt_pkg::RegSizeY: csr_prdata = {1'b0, sy_ff};
         vtlt_pkg::RegSizeZ: csr_prdata = {1'b0, sz_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minx_ff <= vtlt_pkg::MinReset; miny_ff <= vtlt_pkg::MinReset;
         minz_ff <= vtlt_pkg::MinReset; sx_ff <= vtlt_pkg::SizeReset;
         sy_ff <= vtlt_pkg::SizeReset; sz_ff <= vtlt_pkg::SizeReset;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (ridx)
            vtlt_pkg::RegMinX: minx_ff <= csr_pwdata;
            vtlt_pkg::RegMinY: miny_ff <= csr_pwdata;
            vtlt_pkg::RegMinZ: minz_ff <= csr_pwdata;
            vtlt_pkg::RegSizeX: sx_ff <= csr_pwdata[30:0];
            vtlt_pkg::RegSizeY: sy_ff <= csr_pwdata[30:0];
            vtlt_pkg::RegSizeZ: sz_ff <= csr_pwdata[30:0];
            default: ;
         endcase
      end
   end

   vtlt_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .in_cmd(in_cmd), .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   vtlt_back #(.CELLS_X(CELLS_X), .CELLS_Y(CELLS_Y), .CELLS_Z(CELLS_Z)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(q_valid), .cmd_ready(q_ready),
      .cmd(q_cmd), .min_x(minx_ff), .min_y(miny_ff), .min_z(minz_ff),
      .size_x(sx_ff), .size_y(sy_ff), .size_z(sz_ff),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp(rsp)
   );

   assign rsp_tdata = {1'b0, rsp.mesh_hit, rsp.cells_visited, rsp.tally_value};

endmodule
